### src/assert_macros.svh
// Assertion helpers for the contrast stretch block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define RCS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define RCS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define RCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

### src/rcs_pkg.sv
package rcs_pkg;

	localparam int PIX_W   = 8;
	localparam int CMD_W   = 2;
	localparam int CFG_IDX_W = 2;
	// Quotient bits produced by the lane divider, one per step.
	localparam int DIV_STEPS = 8;
	localparam int STEP_CNT_W = 3;

	typedef logic [PIX_W-1:0] pix_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR   = 2'd0,
		CMD_ACCUM   = 2'd1,
		CMD_STRETCH = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_EN_RED   = 2'd0,
		CFG_EN_GREEN = 2'd1,
		CFG_EN_BLUE  = 2'd2,
		CFG_RSVD     = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_HAND
	} state_t;

	typedef struct packed {
		logic clear;
		logic track;
		logic start;
		logic step;
	} lane_ctl_t;

	localparam pix_t PIX_MAX = 8'd255;
	localparam pix_t PIX_MIN = 8'd0;

endpackage

### src/rcs_in_if.sv
interface rcs_in_if;
	import rcs_pkg::*;
	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   command;
	logic [PIX_W-1:0]   red_in;
	logic [PIX_W-1:0]   green_in;
	logic [PIX_W-1:0]   blue_in;

	modport source (output valid, command, red_in, green_in, blue_in, input ready);
	modport sink (input valid, command, red_in, green_in, blue_in, output ready);
endinterface

### src/rcs_out_if.sv
interface rcs_out_if;
	import rcs_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] red_out;
	logic [PIX_W-1:0] green_out;
	logic [PIX_W-1:0] blue_out;

	modport source (output valid, red_out, green_out, blue_out, input ready);
	modport sink (input valid, red_out, green_out, blue_out, output ready);
endinterface

### src/rcs_cfg_if.sv
interface rcs_cfg_if;
	import rcs_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic                 data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### src/rcs_lane.sv
module rcs_lane (
	input  logic              clk,
	input  logic              arst_n,
	input  rcs_pkg::lane_ctl_t ctl,
	input  logic              en,
	input  rcs_pkg::pix_t     pix,
	output rcs_pkg::pix_t     result
);
	import rcs_pkg::*;

	pix_t         lo_q;
	pix_t         hi_q;
	logic         byp_q;
	pix_t         byp_val_q;
	logic [8:0]   rem_q;
	pix_t         num_q;
	logic [8:0]   div_q;
	pix_t         quo_q;

	pix_t         x;
	pix_t         d;
	logic [16:0]  num;
	logic [9:0]   trial;
	logic [9:0]   diff;
	logic         ge;

	always_comb begin
		x   = pix - lo_q;
		d   = hi_q - lo_q;
		// 510*x + d, the rounding numerator over a divisor of 2*d.
		num = {x, 9'b0} - {8'b0, x, 1'b0} + {9'b0, d};
		trial = {rem_q, num_q[PIX_W-1]};
		diff  = trial - {1'b0, div_q};
		ge    = (trial >= {1'b0, div_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q <= PIX_MAX;
			hi_q <= PIX_MIN;
		end else if (ctl.clear) begin
			lo_q <= PIX_MAX;
			hi_q <= PIX_MIN;
		end else if (ctl.track && en) begin
			if (pix < lo_q) lo_q <= pix;
			if (pix > hi_q) hi_q <= pix;
		end
	end

	// Restoring divider. The quotient fits in eight bits because the
	// component is strictly below the maximum whenever it runs.
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= num[16:8];
			num_q <= num[7:0];
			div_q <= {d, 1'b0};
			quo_q <= PIX_MIN;
			priority if (!en || hi_q <= lo_q) begin
				byp_q     <= 1'b1;
				byp_val_q <= pix;
			end else if (pix < lo_q) begin
				byp_q     <= 1'b1;
				byp_val_q <= PIX_MIN;
			end else if (pix >= hi_q) begin
				byp_q     <= 1'b1;
				byp_val_q <= PIX_MAX;
			end else begin
				byp_q     <= 1'b0;
				byp_val_q <= pix;
			end
		end else if (ctl.step) begin
			rem_q <= ge ? diff[8:0] : trial[8:0];
			num_q <= {num_q[PIX_W-2:0], 1'b0};
			quo_q <= {quo_q[PIX_W-2:0], ge};
		end
	end

	assign result = byp_q ? byp_val_q : quo_q;

endmodule

### src/rcs_merge.sv
module rcs_merge (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  rcs_pkg::pix_t red,
	input  rcs_pkg::pix_t green,
	input  rcs_pkg::pix_t blue,
	output logic          can_load,
	rcs_out_if.source     pix_out
);
	import rcs_pkg::*;

	logic valid_q;
	pix_t red_q;
	pix_t green_q;
	pix_t blue_q;

	assign can_load = !valid_q || pix_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (pix_out.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			red_q   <= red;
			green_q <= green;
			blue_q  <= blue;
		end
	end

	assign pix_out.valid     = valid_q;
	assign pix_out.red_out   = red_q;
	assign pix_out.green_out = green_q;
	assign pix_out.blue_out  = blue_q;

endmodule

### src/rgb_contrast_stretch_unit.sv
// Channel   Dir  Handshake     Payload
// pix_in    in   valid/ready   command, red_in, green_in, blue_in
// pix_out   out  valid/ready   red_out, green_out, blue_out
// cfg       in   valid/ready   index, data (enable bit)
//
// Clear and accumulate transactions take effect on the edge that accepts them.
// A stretch transaction occupies the block from acceptance through the
// eight-step restoring divider in each channel lane and the hand-off.
// Results sit in an output register, so input is taken while one waits.
// Reset sets all enables, minimum 255 and maximum 0 per channel.
`include "assert_macros.svh"

module rgb_contrast_stretch_unit (
	input  logic      clk,
	input  logic      arst_n,
	rcs_in_if.sink    pix_in,
	rcs_out_if.source pix_out,
	rcs_cfg_if.sink   cfg
);
	import rcs_pkg::*;

	state_t                state_q;
	state_t                state_nxt;
	logic [STEP_CNT_W-1:0] cnt_q;
	logic                  en_red_q;
	logic                  en_green_q;
	logic                  en_blue_q;

	lane_ctl_t ctl;
	logic      accept;
	logic      load;
	logic      can_load;
	cmd_t      cmd;
	pix_t      red_res;
	pix_t      green_res;
	pix_t      blue_res;

	localparam logic [STEP_CNT_W-1:0] LAST_STEP = STEP_CNT_W'(DIV_STEPS - 1);

	assign cmd    = cmd_t'(pix_in.command);
	assign accept = pix_in.valid && pix_in.ready;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && cmd == CMD_STRETCH) state_nxt = ST_DIV;
			end
			ST_DIV: begin
				if (cnt_q == LAST_STEP) state_nxt = ST_HAND;
			end
			ST_HAND: begin
				if (can_load) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		pix_in.ready = (state_q == ST_IDLE);
		ctl.clear    = accept && cmd == CMD_CLEAR;
		ctl.track    = accept && cmd == CMD_ACCUM;
		ctl.start    = accept && cmd == CMD_STRETCH;
		ctl.step     = (state_q == ST_DIV);
		load         = (state_q == ST_HAND) && can_load;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (ctl.step) cnt_q <= cnt_q + 1'b1;
			else cnt_q <= '0;
		end
	end

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_red_q   <= 1'b1;
			en_green_q <= 1'b1;
			en_blue_q  <= 1'b1;
		end else if (cfg.valid) begin
			unique case (cfg_idx_t'(cfg.index))
				CFG_EN_RED:   en_red_q   <= cfg.data;
				CFG_EN_GREEN: en_green_q <= cfg.data;
				CFG_EN_BLUE:  en_blue_q  <= cfg.data;
				CFG_RSVD:     ;
				default:      ;
			endcase
		end
	end

	rcs_lane u_lane_red (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.en     (en_red_q),
		.pix    (pix_in.red_in),
		.result (red_res)
	);

	rcs_lane u_lane_green (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.en     (en_green_q),
		.pix    (pix_in.green_in),
		.result (green_res)
	);

	rcs_lane u_lane_blue (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.en     (en_blue_q),
		.pix    (pix_in.blue_in),
		.result (blue_res)
	);

	rcs_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.red      (red_res),
		.green    (green_res),
		.blue     (blue_res),
		.can_load (can_load),
		.pix_out  (pix_out)
	);

	`RCS_ASSERT_NEXT(a_stretch_starts_div, clk, arst_n, ctl.start, state_q == ST_DIV && cnt_q == '0, "stretch did not start the divider")
	`RCS_ASSERT_NEXT(a_div_ends_in_hand, clk, arst_n, state_q == ST_DIV && cnt_q == LAST_STEP, state_q == ST_HAND, "divider did not finish after its last step")
	`RCS_ASSERT_NEXT(a_load_sets_valid, clk, arst_n, load, pix_out.valid && state_q == ST_IDLE, "result hand-off was lost")
	`RCS_ASSERT_SAME(a_no_track_busy, clk, arst_n, state_q != ST_IDLE, !ctl.clear && !ctl.track && !ctl.start, "statistics touched during a stretch")

endmodule
